// ===== rtl/imd_pkg.sv =====
// ----------------------------------------------------------------------------
// imd_pkg - shared types and constants of the ISBN missing digit solver
// Item structs, symbol kinds, status codes and sizing of the datapath.
// ----------------------------------------------------------------------------
package imd_pkg;

  // symbols in one code
  localparam int CODE_LENGTH = 10;

  localparam int SUM_W   = 14;
  localparam int CNT_W   = 4;
  localparam int MOD_W   = 8;
  localparam int DIV_W   = 2 * MOD_W;
  localparam int STEP_W  = $clog2(DIV_W);

  localparam logic [CNT_W-1:0] CODE_LEN_C = CNT_W'(CODE_LENGTH);
  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [MOD_W-1:0] MOD_RESET  = MOD_W'(11);

  // symbol kinds
  localparam logic [1:0] KIND_DIGIT   = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SOLVED     = 2'd0;
  localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
  localparam logic [1:0] ST_MULTI_UNK  = 2'd2;
  localparam logic [1:0] ST_NO_INVERSE = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [MOD_W-1:0] digit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [MOD_W-1:0] missing_digit;
    logic [3:0]       coefficient;
    logic [MOD_W-1:0] residue;
  } out_item_t;

  // running state of the code being read
  typedef struct packed {
    logic [SUM_W-1:0] weighted_sum;
    logic [CNT_W-1:0] symbol_count;
    logic [1:0]       unknown_count;
    logic [CNT_W-1:0] unknown_position;
  } acc_t;

endpackage

// ===== rtl/isbn_missing_digit_solver.sv =====
// ----------------------------------------------------------------------------
// isbn_missing_digit_solver - solves the single unknown of an ISBN-10 code
// Digit and unknown symbols are taken while busy stays low.
// End symbol: busy rises; the strobe follows the residue division when a
// check fails, else three 16-step divisions and the inverse search.
// Throughput: one symbol per cycle while busy is low; none while busy.
// Reset (rst_n low, synchronous) clears the code state and sets modulus to 11.
// ----------------------------------------------------------------------------
module isbn_missing_digit_solver (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  imd_pkg::in_item_t         in_data,
  output logic                      out_valid,
  output imd_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [imd_pkg::MOD_W-1:0] cfg_data
);
  import imd_pkg::*;

  logic             take;
  logic             finish;
  logic [MOD_W-1:0] modulus_r;
  acc_t             acc;

  // input transfer
  assign take   = start && !busy;
  assign finish = take && (in_data.kind == KIND_END);

  // modulus register
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus_r <= cfg_data;
    end
  end

  imd_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .acc   (acc)
  );

  imd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .finish    (finish),
    .acc       (acc),
    .modulus   (modulus_r),
    .busy      (busy),
    .res_valid (out_valid),
    .res       (out_data)
  );

endmodule

// ===== rtl/imd_csub.sv =====
// ----------------------------------------------------------------------------
// imd_csub - shared compare and subtract unit
// Reduces a value below twice the modulus into the range 0 .. modulus-1.
// ----------------------------------------------------------------------------
module imd_csub (
  input  logic [imd_pkg::MOD_W:0]   a,
  input  logic [imd_pkg::MOD_W-1:0] m,
  output logic [imd_pkg::MOD_W-1:0] r
);
  import imd_pkg::*;

  logic [MOD_W:0] diff;

  // one conditional subtract
  assign diff = a - {1'b0, m};
  assign r    = (a >= {1'b0, m}) ? diff[MOD_W-1:0] : a[MOD_W-1:0];

endmodule

// ===== rtl/imd_accum.sv =====
// ----------------------------------------------------------------------------
// imd_accum - symbol accumulator
// Keeps the position weighted sum, symbol count and first unknown position.
// ----------------------------------------------------------------------------
module imd_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  imd_pkg::in_item_t item,
  output imd_pkg::acc_t     acc
);
  import imd_pkg::*;

  acc_t              acc_r, acc_nxt;
  logic [CNT_W-1:0]  weight;
  logic [CNT_W+MOD_W-1:0] term;

  // weight of the current position, from 1
  assign weight = acc_r.symbol_count + CNT_W'(1);
  assign term   = weight * item.digit;

  always_comb begin
    acc_nxt = acc_r;
    if (take) begin
      unique case (item.kind)
        KIND_DIGIT: begin
          if (acc_r.symbol_count < CODE_LEN_C) begin
            acc_nxt.weighted_sum = acc_r.weighted_sum + SUM_W'(term);
          end
          if (acc_r.symbol_count != COUNT_MAX) begin
            acc_nxt.symbol_count = weight;
          end
        end
        KIND_UNKNOWN: begin
          if (acc_r.unknown_count == 2'd0) begin
            acc_nxt.unknown_position = acc_r.symbol_count;
          end
          if (acc_r.unknown_count < 2'd2) begin
            acc_nxt.unknown_count = acc_r.unknown_count + 2'd1;
          end
          if (acc_r.symbol_count != COUNT_MAX) begin
            acc_nxt.symbol_count = weight;
          end
        end
        KIND_END: begin
          acc_nxt = '0;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/imd_seq.sv =====
// ----------------------------------------------------------------------------
// imd_seq - end of code sequencer
// Drives the shared compare and subtract unit through residue, coefficient
// reduction, inverse search and the final product reduction.
// ----------------------------------------------------------------------------
module imd_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      finish,
  input  imd_pkg::acc_t             acc,
  input  logic [imd_pkg::MOD_W-1:0] modulus,
  output logic                      busy,
  output logic                      res_valid,
  output imd_pkg::out_item_t        res
);
  import imd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RES  = 6'b000010,
    S_COEF = 6'b000100,
    S_SRCH = 6'b001000,
    S_MISS = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0]  cred_r, cred_nxt;
  logic [MOD_W-1:0]  prod_r, prod_nxt;
  logic [MOD_W-1:0]  k_r, k_nxt;
  logic              len_bad_r, len_bad_nxt;
  logic              multi_r, multi_nxt;
  out_item_t         res_r, res_nxt;

  logic [MOD_W:0]    unit_a;
  logic [MOD_W-1:0]  unit_r;
  logic [MOD_W-1:0]  neg;
  logic              small_mod;

  assign small_mod = (modulus < MOD_W'(2));
  assign neg       = (res_r.residue == '0) ? '0 : modulus - res_r.residue;

  // operand select for the shared unit
  always_comb begin
    if (state_r == S_SRCH) begin
      unit_a = {1'b0, prod_r} + {1'b0, cred_r};
    end else begin
      unit_a = {rem_r, div_r[DIV_W-1]};
    end
  end

  imd_csub u_csub (
    .a (unit_a),
    .m (modulus),
    .r (unit_r)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    div_nxt     = div_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    cred_nxt    = cred_r;
    prod_nxt    = prod_r;
    k_nxt       = k_r;
    len_bad_nxt = len_bad_r;
    multi_nxt   = multi_r;
    res_nxt     = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (finish) begin
          div_nxt               = DIV_W'(acc.weighted_sum);
          rem_nxt               = '0;
          cnt_nxt               = '1;
          len_bad_nxt           = (acc.symbol_count != CODE_LEN_C);
          multi_nxt             = (acc.unknown_count > 2'd1);
          res_nxt.missing_digit = '0;
          res_nxt.coefficient   = (acc.unknown_count != 2'd0) ?
                                  acc.unknown_position + 4'd1 : 4'd0;
          state_nxt             = S_RES;
        end
      end

      S_RES: begin
        rem_nxt = unit_r;
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          res_nxt.residue = small_mod ? '0 : unit_r;
          priority if (len_bad_r) begin
            res_nxt.status = ST_BAD_LENGTH;
            state_nxt      = S_OUT;
          end else if (multi_r) begin
            res_nxt.status = ST_MULTI_UNK;
            state_nxt      = S_OUT;
          end else if (res_r.coefficient == 4'd0 || small_mod) begin
            res_nxt.status = ST_NO_INVERSE;
            state_nxt      = S_OUT;
          end else begin
            div_nxt   = DIV_W'(res_r.coefficient);
            rem_nxt   = '0;
            cnt_nxt   = '1;
            state_nxt = S_COEF;
          end
        end
      end

      S_COEF: begin
        rem_nxt = unit_r;
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          cred_nxt  = unit_r;
          prod_nxt  = unit_r;
          k_nxt     = MOD_W'(1);
          state_nxt = S_SRCH;
        end
      end

      // trial search: prod holds k * coefficient mod modulus
      S_SRCH: begin
        priority if (prod_r == MOD_W'(1)) begin
          div_nxt   = neg * k_r;
          rem_nxt   = '0;
          cnt_nxt   = '1;
          state_nxt = S_MISS;
        end else if (k_r == modulus - MOD_W'(1)) begin
          res_nxt.status = ST_NO_INVERSE;
          state_nxt      = S_OUT;
        end else begin
          prod_nxt = unit_r;
          k_nxt    = k_r + MOD_W'(1);
        end
      end

      S_MISS: begin
        rem_nxt = unit_r;
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          res_nxt.missing_digit = unit_r;
          res_nxt.status        = ST_SOLVED;
          state_nxt             = S_OUT;
        end
      end

      S_OUT: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    cred_r    <= cred_nxt;
    prod_r    <= prod_nxt;
    k_r       <= k_nxt;
    len_bad_r <= len_bad_nxt;
    multi_r   <= multi_nxt;
    res_r     <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res       = res_r;

endmodule

// ===== sim/tb_isbn_missing_digit_solver.sv =====
// ----------------------------------------------------------------------------
// tb_isbn_missing_digit_solver - self-checking bench of the missing digit solver
// Feeds codes symbol by symbol through the start/busy port and predicts each
// end-of-code answer. Directed codes come first, then random codes, most of
// them well formed. Phases use several moduli, the extremes included. Answers
// are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_isbn_missing_digit_solver;
  import imd_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int IDLE_WAIT = 320;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PRINT_MAX = 40;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // predicts answers and holds the ones still to arrive
  class code_checker;
    logic [MOD_W-1:0] modulus;
    logic [SUM_W-1:0] weighted_sum;
    logic [CNT_W-1:0] symbol_count;
    logic [1:0]       unknown_count;
    logic [CNT_W-1:0] unknown_position;
    out_item_t        pending_answers[$];
    int               errors;

    function new();
      modulus = MOD_RESET;
      errors = 0;
      clear_code();
    endfunction

    function void clear_code();
      weighted_sum = '0;
      symbol_count = '0;
      unknown_count = '0;
      unknown_position = '0;
    endfunction

    // smallest k with k * c == 1 mod m, 0 when there is none
    function int inverse_of(int c, int m);
      int k;
      if (m < 2) return 0;
      for (k = 1; k < m; k++) begin
        if ((k * c) % m == 1) return k;
      end
      return 0;
    endfunction

    task flag_mismatch(string what, int got, int want);
      if (errors < PRINT_MAX)
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      errors++;
    endtask

    // one accepted symbol
    function void note_symbol(in_item_t it);
      int m;
      int res;
      int coef;
      int inv;
      out_item_t ans;
      case (it.kind)
        KIND_DIGIT: begin
          if (int'(symbol_count) < CODE_LENGTH)
            weighted_sum = SUM_W'((int'(weighted_sum)
                           + (int'(symbol_count) + 1) * int'(it.digit)) & 16'h3FFF);
          if (symbol_count != COUNT_MAX) symbol_count++;
        end
        KIND_UNKNOWN: begin
          if (unknown_count == 2'd0) unknown_position = symbol_count;
          if (unknown_count < 2'd2) unknown_count++;
          if (symbol_count != COUNT_MAX) symbol_count++;
        end
        KIND_END: begin
          m = int'(modulus);
          res = (m >= 2) ? int'(weighted_sum) % m : 0;
          coef = (unknown_count != 2'd0) ? ((int'(unknown_position) + 1) & 15) : 0;
          ans.missing_digit = '0;
          if (int'(symbol_count) != CODE_LENGTH) begin
            ans.status = ST_BAD_LENGTH;
          end else if (unknown_count > 2'd1) begin
            ans.status = ST_MULTI_UNK;
          end else begin
            inv = (coef != 0) ? inverse_of(coef, m) : 0;
            if (inv == 0) begin
              ans.status = ST_NO_INVERSE;
            end else begin
              ans.status = ST_SOLVED;
              ans.missing_digit = MOD_W'((((m - res) % m) * inv) % m);
            end
          end
          ans.coefficient = 4'(coef);
          ans.residue = MOD_W'(res);
          pending_answers.push_back(ans);
          clear_code();
        end
        default: ;
      endcase
    endfunction

    // one strobed answer against the oldest prediction
    task check_answer(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        flag_mismatch("unexpected answer, status", got.status, -1);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", got.status, want.status);
        if (got.missing_digit !== want.missing_digit)
          flag_mismatch("missing_digit", got.missing_digit, want.missing_digit);
        if (got.coefficient !== want.coefficient)
          flag_mismatch("coefficient", got.coefficient, want.coefficient);
        if (got.residue !== want.residue)
          flag_mismatch("residue", got.residue, want.residue);
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_data = '0;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_data = '0;

  code_checker board;
  bit          calm = 1'b0;
  int          cycle_count = 0;

  isbn_missing_digit_solver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // answer monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_answer(out_data);
  end

  // random idle before a transfer: mostly none or short, a few long
  task idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r == 0) calm = ~calm;
    n = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 95) n = $urandom_range(10, 60);
      else if (r >= 70) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // one symbol transfer, start left high for a back-to-back follower
  task send_symbol(logic [1:0] kind, logic [MOD_W-1:0] digit);
    in_item_t it;
    it.kind = kind;
    it.digit = digit;
    idle_gap();
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_symbol(it);
  endtask

  // wait for all answers and for the block to finish any trailing work
  task settle();
    start <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task write_modulus(logic [MOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.modulus = value;
  endtask

  // one random code with its end symbol; mostly well formed
  task send_random_code(output int sent);
    int mode;
    int len;
    int unk_at;
    int unk_two;
    int i;
    bit wide;
    logic [1:0] kind;
    logic [MOD_W-1:0] digit;
    mode = $urandom_range(0, 99);
    wide = ($urandom_range(0, 3) == 0);
    len = (mode >= 70 && mode < 85) ? $urandom_range(0, 20) : CODE_LENGTH;
    unk_at = $urandom_range(0, CODE_LENGTH - 1);
    unk_two = (unk_at + 1 + $urandom_range(0, CODE_LENGTH - 2)) % CODE_LENGTH;
    for (i = 0; i < len; i++) begin
      // occasional spare-kind noise, ignored by the block
      if ($urandom_range(0, 99) < 3) send_symbol(KIND_SPARE, MOD_W'($urandom_range(0, 255)));
      digit = wide ? MOD_W'($urandom_range(0, 255)) : MOD_W'($urandom_range(0, 10));
      if (mode < 70)
        kind = (i == unk_at) ? KIND_UNKNOWN : KIND_DIGIT;
      else if (mode < 85)
        kind = ($urandom_range(0, 3) == 0) ? KIND_UNKNOWN : KIND_DIGIT;
      else if (mode < 90)
        kind = KIND_DIGIT;
      else
        kind = (i == unk_at || i == unk_two || $urandom_range(0, 7) == 0) ?
               KIND_UNKNOWN : KIND_DIGIT;
      if (kind == KIND_UNKNOWN) digit = MOD_W'($urandom_range(0, 255));
      send_symbol(kind, digit);
    end
    send_symbol(KIND_END, MOD_W'($urandom_range(0, 255)));
    sent = len + 1;
  endtask

  initial begin
    int code_one[9];
    int code_two[9];
    int phase_mod[7];
    int phase_items[7];
    int p;
    int i;
    int budget;
    int sent;
    code_one = '{8, 0, 4, 4, 2, 9, 5, 7, 10};
    code_two = '{255, 0, 1, 2, 3, 4, 5, 6, 7};
    phase_mod = '{2, 255, 0, 1, 10, 0, 11};
    phase_items = '{150, 150, 60, 60, 200, 200, 800};
    phase_mod[5] = $urandom_range(2, 255);
    board = new();

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unknown first with X last, unknown last with extreme digits
    send_symbol(KIND_UNKNOWN, 8'hFF);
    for (i = 0; i < 9; i++) send_symbol(KIND_DIGIT, MOD_W'(code_one[i]));
    send_symbol(KIND_END, 8'h00);
    for (i = 0; i < 9; i++) send_symbol(KIND_DIGIT, MOD_W'(code_two[i]));
    send_symbol(KIND_UNKNOWN, 8'h00);
    send_symbol(KIND_END, 8'hFF);
    // empty code, then an ignored spare kind
    send_symbol(KIND_END, 8'h55);
    send_symbol(KIND_SPARE, 8'hFF);
    settle();

    // random phases, one modulus each
    for (p = 0; p < 7; p++) begin
      write_modulus(MOD_W'(phase_mod[p]));
      budget = phase_items[p];
      while (budget > 0) begin
        send_random_code(sent);
        budget -= sent;
      end
      settle();
    end

    if (board.errors == 0 && board.pending_answers.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
